@@ rtl/assert_macros.svh @@
// Assertion macros included by the RTL sniffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/tes_pkg.sv @@
// Package for the text encoding sniffer: beat types, encoding codes, mark bytes.
`default_nettype none

package tes_pkg;

   localparam int DEFAULT_COUNT_BITS = 32;
   localparam int OUT_COUNT_BITS     = 32;

   // Encoding verdict codes
   localparam logic [2:0] ENC_NONE    = 3'd0;
   localparam logic [2:0] ENC_UTF8    = 3'd1;
   localparam logic [2:0] ENC_UTF7    = 3'd2;
   localparam logic [2:0] ENC_UTF16LE = 3'd3;
   localparam logic [2:0] ENC_UTF16BE = 3'd4;

   // Byte order mark bytes
   localparam logic [7:0] BOM8_0   = 8'hEF;
   localparam logic [7:0] BOM8_1   = 8'hBB;
   localparam logic [7:0] BOM8_2   = 8'hBF;
   localparam logic [7:0] BOM7_0   = 8'h2B;
   localparam logic [7:0] BOM7_1   = 8'h2F;
   localparam logic [7:0] BOM7_2   = 8'h76;
   localparam logic [7:0] BOM7_3A  = 8'h38;
   localparam logic [7:0] BOM7_3B  = 8'h39;
   localparam logic [7:0] BOM7_3C  = 8'h2B;
   localparam logic [7:0] BOM7_3D  = 8'h2F;
   localparam logic [7:0] BOM16_FF = 8'hFF;
   localparam logic [7:0] BOM16_FE = 8'hFE;

   // Lead byte limits
   localparam logic [7:0] LEAD_OVERLONG_HI = 8'hC1;
   localparam logic [7:0] LEAD_RANGE_LIMIT = 8'hF5;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]                encoding;
      logic                      from_mark;
      logic                      utf8_valid;
      logic [OUT_COUNT_BITS-1:0] nonascii_total;
      logic [OUT_COUNT_BITS-1:0] odd_nul_total;
      logic [OUT_COUNT_BITS-1:0] even_nul_total;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/text_encoding_sniffer.sv @@
// Text encoding sniffer: byte order mark check, NUL counts and UTF-8 validation.
//
// Usage:
//   The req channel carries one byte of a text buffer per beat, with last_byte
//   marking the final byte. A beat is taken at a rising clock edge where
//   req_valid is high and req_stall is low. Beats without last_byte give no
//   result; the beat with last_byte gives exactly one verdict on rsp_data.
//   The verdict is registered: it is valid on rsp the cycle after its last byte is taken.
//   Throughput: one byte per cycle while req_stall is low, set by the single
//   pass of compare and counter-increment logic between the state registers
//   and the result register.
//   The result register holds its beat while rsp_stall is high; req_stall rises
//   for every byte while that register is full and stalled, so the input waits
//   until the pending verdict leaves. With rsp_stall low the slot reloads in the
//   same cycle its old verdict is taken, so buffers stream without a gap.
//   Reset (synchronous, active high) clears the buffer state and empties the
//   result register. The buffer state clears itself after every last byte.
//   Counters saturate at 2^COUNT_BITS - 1; the result carries their low 32 bits.
`default_nettype none

module text_encoding_sniffer #(
   parameter int COUNT_BITS = tes_pkg::DEFAULT_COUNT_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire tes_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      tes_pkg::rsp_type rsp_data
);
   import tes_pkg::*;

   `include "assert_macros.svh"

   localparam int WIDE_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

   typedef logic [COUNT_BITS-1:0] count_type;

   function automatic count_type sat_inc(input count_type v);
      sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
   endfunction

   function automatic logic [OUT_COUNT_BITS-1:0] to_out(input count_type v);
      logic [WIDE_BITS-1:0] wide;
      wide   = WIDE_BITS'(v);
      to_out = wide[OUT_COUNT_BITS-1:0];
   endfunction

   // Buffer state
   logic [7:0] head_ff [4];
   logic [7:0] head_in [4];
   logic [2:0] seen_ff, seen_in;
   logic       parity_ff, parity_in;
   logic [1:0] tails_ff, tails_in;
   logic       valid_ff, valid_in;
   count_type  nonascii_ff, nonascii_in;
   count_type  odd_nul_ff, odd_nul_in;
   count_type  even_nul_ff, even_nul_in;

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic       req_accept;
   logic       load;
   logic [7:0] b;
   logic       final_valid;
   logic       is_utf7_fourth;

   // Stall input only when the result slot is occupied and held.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign load       = req_accept & req_data.last_byte;
   assign b          = req_data.byte_value;

   // Per-byte step: validation, NUL and non-ASCII counting
   always_comb begin
      tails_in    = tails_ff;
      valid_in    = valid_ff;
      nonascii_in = nonascii_ff;
      odd_nul_in  = odd_nul_ff;
      even_nul_in = even_nul_ff;
      priority if (tails_ff != 2'd0) begin
         // Tail candidate: count, then advance or break the sequence.
         if (b[7]) begin
            nonascii_in = sat_inc(nonascii_ff);
         end
         if (b[7:6] == 2'b10) begin
            tails_in = tails_ff - 2'd1;
         end else begin
            valid_in = 1'b0;
            tails_in = 2'd0;
         end
      end else if (b == 8'h00) begin
         if (parity_ff) begin
            odd_nul_in = sat_inc(odd_nul_ff);
         end else begin
            even_nul_in = sat_inc(even_nul_ff);
         end
      end else if (b[7]) begin
         nonascii_in = sat_inc(nonascii_ff);
         if (valid_ff) begin
            if (b[6]) begin
               // Lead byte: pick the tail count from the prefix.
               priority if (!b[5]) begin
                  tails_in = 2'd1;
                  if (b <= LEAD_OVERLONG_HI) begin
                     valid_in = 1'b0;
                  end
               end else if (!b[4]) begin
                  tails_in = 2'd2;
               end else if (!b[3]) begin
                  tails_in = 2'd3;
                  if (b >= LEAD_RANGE_LIMIT) begin
                     valid_in = 1'b0;
                  end
               end else begin
                  valid_in = 1'b0;
               end
            end else begin
               // Stray tail byte
               valid_in = 1'b0;
            end
         end
      end else begin
         // Plain ASCII: nothing to count
      end
   end

   // Keep the first four bytes for the mark check.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         head_in[i] = head_ff[i];
      end
      seen_in = seen_ff;
      if (seen_ff < 3'd4) begin
         head_in[seen_ff[1:0]] = b;
         seen_in               = seen_ff + 3'd1;
      end
      parity_in = ~parity_ff;
   end

   // Verdict for the beat carrying the last byte
   always_comb begin
      final_valid    = valid_in & (tails_in == 2'd0);
      is_utf7_fourth = (head_in[3] == BOM7_3A) || (head_in[3] == BOM7_3B) ||
                       (head_in[3] == BOM7_3C) || (head_in[3] == BOM7_3D);
      rsp_in                = '0;
      rsp_in.from_mark      = 1'b1;
      priority if (seen_in >= 3'd3 && head_in[0] == BOM8_0 && head_in[1] == BOM8_1 &&
                   head_in[2] == BOM8_2) begin
         rsp_in.encoding = ENC_UTF8;
      end else if (seen_in >= 3'd4 && head_in[0] == BOM7_0 && head_in[1] == BOM7_1 &&
                   head_in[2] == BOM7_2 && is_utf7_fourth) begin
         rsp_in.encoding = ENC_UTF7;
      end else if (seen_in >= 3'd2 && head_in[0] == BOM16_FF && head_in[1] == BOM16_FE) begin
         rsp_in.encoding = ENC_UTF16LE;
      end else if (seen_in >= 3'd2 && head_in[0] == BOM16_FE && head_in[1] == BOM16_FF) begin
         rsp_in.encoding = ENC_UTF16BE;
      end else begin
         // No mark: decide from the statistics and report them.
         rsp_in.from_mark      = 1'b0;
         rsp_in.utf8_valid     = final_valid;
         rsp_in.nonascii_total = to_out(nonascii_in);
         rsp_in.odd_nul_total  = to_out(odd_nul_in);
         rsp_in.even_nul_total = to_out(even_nul_in);
         priority if (odd_nul_in != '0 || even_nul_in != '0) begin
            rsp_in.encoding = ENC_UTF16LE;
         end else if (nonascii_in != '0 && final_valid) begin
            rsp_in.encoding = ENC_UTF8;
         end else begin
            rsp_in.encoding = ENC_NONE;
         end
      end
   end

   // Advance buffer state; clear it after each last byte.
   always_ff @(posedge clock) begin
      if (reset || load) begin
         for (int i = 0; i < 4; i++) begin
            head_ff[i] <= 8'h00;
         end
         seen_ff     <= 3'd0;
         parity_ff   <= 1'b0;
         tails_ff    <= 2'd0;
         valid_ff    <= 1'b1;
         nonascii_ff <= '0;
         odd_nul_ff  <= '0;
         even_nul_ff <= '0;
      end else if (req_accept) begin
         for (int i = 0; i < 4; i++) begin
            head_ff[i] <= head_in[i];
         end
         seen_ff     <= seen_in;
         parity_ff   <= parity_in;
         tails_ff    <= tails_in;
         valid_ff    <= valid_in;
         nonascii_ff <= nonascii_in;
         odd_nul_ff  <= odd_nul_in;
         even_nul_ff <= even_nul_in;
      end
   end

   // Result slot: fill on a last byte, hold while stalled, drop once taken.
   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `ASSERT_IMPL(a_stall_only_when_full, clock, reset, req_stall, rsp_valid_ff)
   `ASSERT_IMPL(a_mark_zero_stats, clock, reset, rsp_valid_ff && rsp_ff.from_mark,
                !rsp_ff.utf8_valid && rsp_ff.nonascii_total == '0 &&
                rsp_ff.odd_nul_total == '0 && rsp_ff.even_nul_total == '0)
   `ASSERT_IMPL(a_encoding_range, clock, reset, rsp_valid_ff, rsp_ff.encoding <= ENC_UTF16BE)
   `ASSERT_NEXT(a_clear_after_last, clock, reset, load,
                seen_ff == 3'd0 && !parity_ff && tails_ff == 2'd0 && valid_ff && rsp_valid_ff)

endmodule

`default_nettype wire

@@ dv/tb_text_encoding_sniffer.sv @@
// Testbench for text_encoding_sniffer: directed and random buffers checked against a predictor.
`timescale 1ns / 100ps

module tb_text_encoding_sniffer;
   import tes_pkg::*;

   // Counters at the default width of the block.
   localparam int CNT_W      = DEFAULT_COUNT_BITS;
   localparam int IDLE_LIMIT = 3000;
   localparam int RAND_BYTES = 660;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Shared knobs: quiet turns off all idling on both sides.
   logic       quiet = 1'b0;
   int         err_count = 0;
   int         idle_cycles = 0;
   int         random_bytes_sent = 0;
   logic [7:0] buf_bytes[$];

   // Predictor state: one buffer in flight.
   logic [7:0]       head [0:3];
   logic [2:0]       n_head;
   logic             parity;
   logic [1:0]       tails_left;
   logic             utf8_ok;
   logic [CNT_W-1:0] hi_cnt;
   logic [CNT_W-1:0] odd_nuls;
   logic [CNT_W-1:0] even_nuls;

   // Verdicts that the block still owes, oldest first.
   rsp_type pending_verdicts[$];
   rsp_type want_verdict;

   text_encoding_sniffer #(
      .COUNT_BITS(CNT_W)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Idle lengths: mostly none or short, now and then a long one.
   // ---------------------------------------------------------------------
   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

   task automatic clear_sniff_state();
      for (int i = 0; i < 4; i++) head[i] = 8'h00;
      n_head     = '0;
      parity     = 1'b0;
      tails_left = '0;
      utf8_ok    = 1'b1;
      hi_cnt     = '0;
      odd_nuls   = '0;
      even_nuls  = '0;
   endtask

   // ---------------------------------------------------------------------
   // Predictor: advance the sniffer state by one accepted byte and, on the
   // last byte, queue the verdict and clear for the next buffer.
   // ---------------------------------------------------------------------
   task automatic predict_byte(input req_type item);
      logic [7:0] b;
      rsp_type    v;
      b = item.byte_value;
      v = '0;

      if (tails_left != 0) begin
         // Inside a sequence every byte is a tail candidate, valid or not.
         if (b[7]) hi_cnt = sat_inc(hi_cnt);
         if (b[7:6] == 2'b10) begin
            tails_left = tails_left - 1'b1;
         end else begin
            // Breaking byte: end the sequence, never count it as a NUL.
            utf8_ok    = 1'b0;
            tails_left = '0;
         end
      end else if (b == 8'h00) begin
         if (parity) odd_nuls = sat_inc(odd_nuls);
         else        even_nuls = sat_inc(even_nuls);
      end else if (b[7]) begin
         hi_cnt = sat_inc(hi_cnt);
         // Start a new sequence only while validity still holds.
         if (utf8_ok) begin
            if (b[7:6] != 2'b11) begin
               utf8_ok = 1'b0;                      // stray tail byte
            end else if (!b[5]) begin
               tails_left = 2'd1;
               if (b <= LEAD_OVERLONG_HI) utf8_ok = 1'b0;
            end else if (!b[4]) begin
               tails_left = 2'd2;
            end else if (!b[3]) begin
               tails_left = 2'd3;
               if (b >= LEAD_RANGE_LIMIT) utf8_ok = 1'b0;
            end else begin
               utf8_ok = 1'b0;                      // F8-FF never lead
            end
         end
      end

      if (n_head < 3'd4) begin
         head[n_head[1:0]] = b;
         n_head = n_head + 1'b1;
      end
      parity = ~parity;

      if (item.last_byte) begin
         // A sequence cut off by the end of the buffer is invalid.
         if (tails_left != 0) utf8_ok = 1'b0;
         v.from_mark = 1'b1;
         if (n_head >= 3'd3 && head[0] == BOM8_0 && head[1] == BOM8_1 &&
             head[2] == BOM8_2) begin
            v.encoding = ENC_UTF8;
         end else if (n_head >= 3'd4 && head[0] == BOM7_0 && head[1] == BOM7_1 &&
                      head[2] == BOM7_2 &&
                      (head[3] == BOM7_3A || head[3] == BOM7_3B ||
                       head[3] == BOM7_3C || head[3] == BOM7_3D)) begin
            v.encoding = ENC_UTF7;
         end else if (n_head >= 3'd2 && head[0] == BOM16_FF && head[1] == BOM16_FE) begin
            v.encoding = ENC_UTF16LE;
         end else if (n_head >= 3'd2 && head[0] == BOM16_FE && head[1] == BOM16_FF) begin
            v.encoding = ENC_UTF16BE;
         end else begin
            v.from_mark = 1'b0;
            if (odd_nuls != 0 || even_nuls != 0)  v.encoding = ENC_UTF16LE;
            else if (hi_cnt != 0 && utf8_ok)      v.encoding = ENC_UTF8;
            else                                  v.encoding = ENC_NONE;
            v.utf8_valid     = utf8_ok;
            v.nonascii_total = 32'(hi_cnt);
            v.odd_nul_total  = 32'(odd_nuls);
            v.even_nul_total = 32'(even_nuls);
         end
         pending_verdicts.push_back(v);
         clear_sniff_state();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender: optional gap, then hold the beat until it is taken.
   // Valid is only dropped for a gap, so back-to-back beats keep it high.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      req_type     item;
      item.byte_value = b;
      item.last_byte  = last;
      gap = pause_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_byte(item);
   endtask

   task automatic send_buffer();
      foreach (buf_bytes[i]) send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall, with occasional long free-running stretches.
   // ---------------------------------------------------------------------
   initial begin : rsp_stall_driver
      int unsigned n;
      forever begin
         @(posedge clock);
         n = pause_len();
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
         repeat (n) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Checking: sample at the falling edge, where handshake signals are settled
   // and equal to what the next rising edge sees.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      err_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("verdict with none outstanding", 32'(rsp_data.encoding), 0);
         end else begin
            want_verdict = pending_verdicts.pop_front();
            check_field("encoding", 32'(rsp_data.encoding), 32'(want_verdict.encoding));
            check_field("from_mark", 32'(rsp_data.from_mark), 32'(want_verdict.from_mark));
            check_field("utf8_valid", 32'(rsp_data.utf8_valid),
                        32'(want_verdict.utf8_valid));
            check_field("nonascii_total", rsp_data.nonascii_total,
                        want_verdict.nonascii_total);
            check_field("odd_nul_total", rsp_data.odd_nul_total,
                        want_verdict.odd_nul_total);
            check_field("even_nul_total", rsp_data.even_nul_total,
                        want_verdict.even_nul_total);
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Buffer builders for the random part.
   // ---------------------------------------------------------------------
   task automatic add_code_point();
      int unsigned cls;
      int unsigned cp;
      cls = $urandom_range(0, 9);
      if (cls < 5) begin
         buf_bytes.push_back(8'($urandom_range(1, 8'h7F)));
      end else if (cls < 7) begin
         cp = $urandom_range(16'h0080, 16'h07FF);
         buf_bytes.push_back(8'hC0 | 8'(cp >> 6));
         buf_bytes.push_back(8'h80 | 8'(cp & 32'h3F));
      end else if (cls < 9) begin
         cp = $urandom_range(16'h0800, 16'hFFFF);
         buf_bytes.push_back(8'hE0 | 8'(cp >> 12));
         buf_bytes.push_back(8'h80 | 8'((cp >> 6) & 32'h3F));
         buf_bytes.push_back(8'h80 | 8'(cp & 32'h3F));
      end else begin
         cp = $urandom_range(32'h10000, 32'h10FFFF);
         buf_bytes.push_back(8'hF0 | 8'(cp >> 18));
         buf_bytes.push_back(8'h80 | 8'((cp >> 12) & 32'h3F));
         buf_bytes.push_back(8'h80 | 8'((cp >> 6) & 32'h3F));
         buf_bytes.push_back(8'h80 | 8'(cp & 32'h3F));
      end
   endtask

   task automatic add_text(input int unsigned max_points);
      repeat ($urandom_range(0, max_points)) add_code_point();
   endtask

   task automatic build_random_buffer();
      int unsigned kind;
      int unsigned span;
      int unsigned idx;
      buf_bytes.delete();
      kind = $urandom_range(0, 99);
      span = ($urandom_range(0, 9) == 0) ? 30 : 8;
      if (kind < 40) begin
         // Well-formed UTF-8 text.
         add_text(span);
      end else if (kind < 55) begin
         // Mark prefix, sometimes incomplete or off by its last byte.
         case ($urandom_range(0, 5))
            0: buf_bytes = '{BOM8_0, BOM8_1, BOM8_2};
            1: buf_bytes = '{BOM7_0, BOM7_1, BOM7_2,
                             ($urandom_range(0, 1) ? BOM7_3A : BOM7_3B)};
            2: buf_bytes = '{BOM7_0, BOM7_1, BOM7_2,
                             ($urandom_range(0, 1) ? BOM7_3C : 8'($urandom_range(0, 255)))};
            3: buf_bytes = '{BOM16_FF, BOM16_FE};
            4: buf_bytes = '{BOM16_FE, BOM16_FF};
            default: begin
               buf_bytes = '{BOM8_0, BOM8_1, BOM7_0, BOM7_1};
               repeat ($urandom_range(1, 3)) void'(buf_bytes.pop_back());
            end
         endcase
         if ($urandom_range(0, 1)) add_text(span);
      end else if (kind < 70) begin
         // UTF-16 style: nonzero bytes interleaved with NULs in either order.
         repeat ($urandom_range(1, span)) begin
            if (kind[0]) begin
               buf_bytes.push_back(8'($urandom_range(1, 255)));
               buf_bytes.push_back(8'h00);
            end else begin
               buf_bytes.push_back(8'h00);
               buf_bytes.push_back(8'($urandom_range(1, 255)));
            end
         end
      end else if (kind < 85) begin
         // Raw noise over the whole byte range.
         repeat ($urandom_range(1, 2 * span)) buf_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         // Broken UTF-8: corrupt one byte or cut the tail off.
         add_text(span);
         add_code_point();
         if ($urandom_range(0, 1)) begin
            void'(buf_bytes.pop_back());
         end else begin
            idx = $urandom_range(0, buf_bytes.size() - 1);
            buf_bytes[idx] = 8'($urandom_range(0, 255));
         end
      end
      if (buf_bytes.size() == 0) buf_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------
   task automatic test_byte_order_marks();
      buf_bytes = '{BOM8_0, BOM8_1, BOM8_2};                 send_buffer();
      buf_bytes = '{BOM7_0, BOM7_1, BOM7_2, BOM7_3B};        send_buffer();
      // NUL in the fourth place is no UTF-7 mark: the NUL count decides.
      buf_bytes = '{BOM7_0, BOM7_1, BOM7_2, 8'h00};          send_buffer();
      buf_bytes = '{BOM16_FF, BOM16_FE};                     send_buffer();
      buf_bytes = '{BOM16_FE, BOM16_FF};                     send_buffer();
      // One byte is too short for any mark.
      buf_bytes = '{BOM16_FF};                               send_buffer();
   endtask

   task automatic test_utf8_rules();
      buf_bytes = '{8'hC3, 8'hA9};   send_buffer();   // valid two-byte sequence
      buf_bytes = '{8'hC0, 8'h80};   send_buffer();   // overlong lead
      buf_bytes = '{8'hF5, 8'h80};   send_buffer();   // lead past the code range
      buf_bytes = '{8'hE2, 8'h82};   send_buffer();   // sequence left open at the end
      buf_bytes = '{8'h80};          send_buffer();   // tail with no lead
      buf_bytes = '{8'h00};          send_buffer();   // NUL at even offset
      buf_bytes = '{8'h41, 8'h00};   send_buffer();   // NUL at odd offset
      buf_bytes = '{8'hC3, 8'h00};   send_buffer();   // NUL breaking a sequence
      buf_bytes = '{8'h7F};          send_buffer();   // plain ASCII
   endtask

   // Long runs of NULs and high bytes in one buffer.
   task automatic test_long_counts();
      buf_bytes.delete();
      repeat (40) buf_bytes.push_back(8'h00);
      repeat (20) buf_bytes.push_back(8'hFF);
      send_buffer();
   endtask

   task automatic test_random_buffers();
      while (random_bytes_sent < RAND_BYTES) begin
         quiet = ($urandom_range(0, 7) == 0);
         build_random_buffer();
         send_buffer();
         random_bytes_sent += buf_bytes.size();
      end
      quiet = 1'b0;
   endtask

   initial begin
      clear_sniff_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_byte_order_marks();
      test_utf8_rules();
      test_long_counts();
      test_random_buffers();

      // Drop valid, drain the outstanding verdicts, then let the pipe settle.
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (err_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tes_pkg.sv
rtl/text_encoding_sniffer.sv
dv/tb_text_encoding_sniffer.sv
